// ===== rtl/core/aes_pkg.sv =====
// aes_pkg: shared constants, s-box and round helpers for the ctr cipher
// no dependencies
package aes_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int ROUNDS      = 10;
    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    typedef logic [127:0] t_block;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] tbl [256];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tbl[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits in bits 127-8i .. 120-8i
    function automatic logic [7:0] get_byte(input t_block b, input int i);
        return b[127 - 8*i -: 8];
    endfunction

    // round constant for round r (1..10)
    function automatic logic [7:0] rcon(input int r);
        logic [7:0] c;
        c = 8'h01;
        for (int k = 1; k < r; k++) c = xtime(c);
        return c;
    endfunction

    // next round key from the previous one
    function automatic t_block next_key(input t_block k, input logic [7:0] rc);
        t_block o;
        logic [31:0] t;
        logic [31:0] w [4];
        for (int j = 0; j < 4; j++) w[j] = k[127 - 32*j -: 32];
        t = {sbox(w[3][23:16]) ^ rc, sbox(w[3][15:8]), sbox(w[3][7:0]), sbox(w[3][31:24])};
        w[0] = w[0] ^ t;
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
        o = {w[0], w[1], w[2], w[3]};
        return o;
    endfunction

    // subbytes, shiftrows, optional mixcolumns
    function automatic t_block round_fn(input t_block s, input logic mix);
        t_block o;
        logic [7:0] tb [16];
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                tb[r + 4*c] = sbox(get_byte(s, r + 4*((c + r) % 4)));
        for (int c = 0; c < 4; c++) begin
            a0 = tb[4*c]; a1 = tb[4*c+1]; a2 = tb[4*c+2]; a3 = tb[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (mix) begin
                tb[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                tb[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                tb[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                tb[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = tb[i];
        return o;
    endfunction

endpackage

// ===== rtl/core/aes128_ctr_block_cipher.sv =====
// aes128_ctr_block_cipher: pipelined aes-128 counter mode, one block a word
// depends on aes_pkg (s-box, round and key schedule helpers)
//
// usage:
//   s_axis: tdata carries nonce_high, nonce_low, block_number, data_high,
//   data_low, bytes_valid; tlast carries last_block. m_axis: tdata carries
//   result_high, result_low, out_bytes_valid; tlast carries out_last.
//   cfg: write index 0 for key_high, 1 for key_low, only while idle.
// structure: 12 register stages (initial key add, ten round stages, one output
//   stage), the first loaded at the accepting edge; each round stage holds
//   one round function and its own round key expansion.
// throughput: one word per cycle, each stage taking one while not stalled.
// reset: all stage valid bits clear, key registers go to zero.
// stall: full stages with no empty stage after them hold; s_axis_tready
//   stays high while any stage is empty, so bubbles are squeezed out.
module aes128_ctr_block_cipher (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // nonce_high[63:0], nonce_low[119:64], block_number[124:120],
    // data_high[188:125], data_low[252:189], bytes_valid[257:253], pad
    input  logic [263:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_high[63:0], result_low[127:64], out_bytes_valid[132:128], pad
    output logic [135:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [63:0]  i_cfg_data
);
    localparam int NS = aes_pkg::ROUNDS + 1;

    logic [63:0] r_key_high, r_key_low;

    // stage registers: 0 after key add, k after round k
    logic                 r_vld  [NS];
    aes_pkg::t_block      r_st   [NS];
    aes_pkg::t_block      r_rk   [NS];
    aes_pkg::t_block      r_dat  [NS];
    logic [4:0]           r_nb   [NS];
    logic                 r_lst  [NS];

    logic         r_ovld;
    logic [135:0] r_odata;
    logic         r_olast;

    logic adv [NS + 1];
    logic out_free;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == aes_pkg::REG_KEY_HIGH) r_key_high <= i_cfg_data;
            else                                      r_key_low  <= i_cfg_data;
        end
    end

    // a stage advances when the one after it can take its word
    assign out_free = !r_ovld || m_axis_tready;
    always_comb begin
        adv[NS] = out_free;
        for (int k = NS - 1; k >= 0; k--) adv[k] = !r_vld[k] || adv[k + 1];
    end
    assign s_axis_tready = adv[0];

    // first stage: form counter block and add key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld[0] <= 1'b0;
        else if (adv[0]) r_vld[0] <= s_axis_tvalid;
        if (adv[0]) begin
            r_st[0]  <= {s_axis_tdata[63:0], s_axis_tdata[119:64], 3'b000,
                         s_axis_tdata[124:120]} ^ {r_key_high, r_key_low};
            r_rk[0]  <= {r_key_high, r_key_low};
            r_dat[0] <= s_axis_tdata[252:125];
            r_nb[0]  <= s_axis_tdata[257:253];
            r_lst[0] <= s_axis_tlast;
        end
    end

    // round stages
    for (genvar g = 1; g < NS; g++) begin : g_round
        aes_pkg::t_block nk;
        assign nk = aes_pkg::next_key(r_rk[g-1], aes_pkg::rcon(g));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld[g] <= 1'b0;
            else if (adv[g]) r_vld[g] <= r_vld[g-1];
            if (adv[g]) begin
                r_st[g]  <= aes_pkg::round_fn(r_st[g-1], g != aes_pkg::ROUNDS) ^ nk;
                r_rk[g]  <= nk;
                r_dat[g] <= r_dat[g-1];
                r_nb[g]  <= r_nb[g-1];
                r_lst[g] <= r_lst[g-1];
            end
        end
    end

    // output stage: xor keystream, zero invalid bytes
    aes_pkg::t_block n_res;
    always_comb begin
        logic [63:0] hi, lo;
        hi = r_dat[NS-1][63:0];
        lo = r_dat[NS-1][127:64];
        n_res = {hi, lo} ^ r_st[NS-1];
        for (int i = 0; i < aes_pkg::BLOCK_BYTES; i++)
            if (5'(i) >= r_nb[NS-1]) n_res[127 - 8*i -: 8] = 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (out_free) r_ovld <= r_vld[NS-1];
        if (out_free) begin
            r_odata <= {3'b000, r_nb[NS-1], n_res[63:0], n_res[127:64]};
            r_olast <= r_lst[NS-1];
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    // checks
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> s_axis_tready)
        else $error("empty first stage refused input");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-1] && out_free |=> m_axis_tvalid)
        else $error("last round word lost");
endmodule

// ===== dv/aes128_ctr_block_cipher_tb.sv =====
`timescale 1ns / 1ps
// aes128_ctr_block_cipher_tb: self-checking bench for the aes-128 counter mode block
// depends on aes_pkg for register indexes and the rtl top; keystream predicted locally
module aes128_ctr_block_cipher_tb;

    typedef struct packed {
        logic [63:0] nonce_high;
        logic [55:0] nonce_low;
        logic [4:0]  block_number;
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  bytes_valid;
        logic        last_block;
    } t_ctr_word;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic [4:0]  out_bytes_valid;
        logic        out_last;
    } t_cipher_word;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [263:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic         i_cfg_index;
    logic [63:0]  i_cfg_data;

    aes128_ctr_block_cipher DUT (.*);

    localparam int PIPE_DEPTH = 12;

    logic [7:0] sub_table [256];
    logic [127:0] key_reg;
    t_ctr_word    pending_words [$];
    t_cipher_word expected_cipher [$];
    int error_count;
    int words_checked;
    int stall_hold;
    int gap_left;
    int burst_left;
    bit sender_hold;
    bit long_stall_req;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // keystream block: aes-128 of the counter block under the current key
    function automatic logic [127:0] keystream(input logic [127:0] ctr_blk);
        logic [7:0] rk [176];
        logic [7:0] st [16];
        logic [7:0] tb [16];
        logic [7:0] t0, t1, t2, t3, tmp, rc, a0, a1, a2, a3, al;
        logic [127:0] o;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) rk[i] = key_reg[127 - 8*i -: 8];
        for (int i = 16; i < 176; i += 4) begin
            t0 = rk[i-4]; t1 = rk[i-3]; t2 = rk[i-2]; t3 = rk[i-1];
            if (i % 16 == 0) begin
                tmp = t0;
                t0 = sub_table[t1] ^ rc;
                t1 = sub_table[t2];
                t2 = sub_table[t3];
                t3 = sub_table[tmp];
                rc = gf_double(rc);
            end
            rk[i] = rk[i-16] ^ t0; rk[i+1] = rk[i-15] ^ t1;
            rk[i+2] = rk[i-14] ^ t2; rk[i+3] = rk[i-13] ^ t3;
        end
        for (int i = 0; i < 16; i++) st[i] = ctr_blk[127 - 8*i -: 8] ^ rk[i];
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    tb[r + 4*c] = sub_table[st[r + 4*((c + r) % 4)]];
            for (int c = 0; c < 4; c++) begin
                a0 = tb[4*c]; a1 = tb[4*c+1]; a2 = tb[4*c+2]; a3 = tb[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                if (rnd != 10) begin
                    tb[4*c]   = a0 ^ al ^ gf_double(a0 ^ a1);
                    tb[4*c+1] = a1 ^ al ^ gf_double(a1 ^ a2);
                    tb[4*c+2] = a2 ^ al ^ gf_double(a2 ^ a3);
                    tb[4*c+3] = a3 ^ al ^ gf_double(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) st[i] = tb[i] ^ rk[16*rnd + i];
        end
        for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = st[i];
        return o;
    endfunction

    // expected cipher word for one accepted counter word
    function automatic t_cipher_word predict_cipher(input t_ctr_word w);
        t_cipher_word r;
        logic [127:0] ks;
        logic [127:0] dat;
        int nvalid;
        nvalid = (w.bytes_valid > 16) ? 16 : int'(w.bytes_valid);
        ks = keystream({w.nonce_high, w.nonce_low, 3'b000, w.block_number});
        dat = {w.data_high, w.data_low} ^ ks;
        for (int i = 0; i < 16; i++)
            if (i >= nvalid) dat[127 - 8*i -: 8] = 8'h00;
        r.result_high = dat[127:64];
        r.result_low = dat[63:0];
        r.out_bytes_valid = w.bytes_valid;
        r.out_last = w.last_block;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic t_ctr_word random_word(input int nv);
        t_ctr_word w;
        w.nonce_high = {$urandom, $urandom};
        w.nonce_low = 56'({$urandom, $urandom});
        w.block_number = 5'($urandom_range(1, 16));
        w.data_high = {$urandom, $urandom};
        w.data_low = {$urandom, $urandom};
        w.bytes_valid = 5'(nv);
        w.last_block = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // tdata layout: first field in the lowest bits, padded to whole bytes
    function automatic logic [263:0] pack_ctr(input t_ctr_word w);
        return {6'b0, w.bytes_valid, w.data_low, w.data_high, w.block_number,
                w.nonce_low, w.nonce_high};
    endfunction

    // driver: bursts of offered words with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_cipher.push_back(predict_cipher(pending_words.pop_front()));
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // word still waiting, keep it
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_words.size() > 0 && !sender_hold) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pack_ctr(pending_words[0]);
                s_axis_tlast <= pending_words[0].last_block;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_hold <= 0;
        end else if (long_stall_req && stall_hold == 0) begin
            stall_hold <= 60;
            m_axis_tready <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            m_axis_tready <= (stall_hold == 1);
        end else begin
            m_axis_tready <= ($urandom_range(0, 9) < 7) || ($time % 3000 < 800);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_cipher_word got;
        t_cipher_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tdata[132:128],
                   m_axis_tlast};
            if (expected_cipher.size() == 0) begin
                report_mismatch("unexpected word", got.result_high, 64'h0);
            end else begin
                want = expected_cipher.pop_front();
                words_checked++;
                if (got.result_high !== want.result_high)
                    report_mismatch("result_high", got.result_high, want.result_high);
                if (got.result_low !== want.result_low)
                    report_mismatch("result_low", got.result_low, want.result_low);
                if (got.out_bytes_valid !== want.out_bytes_valid)
                    report_mismatch("out_bytes_valid", 64'(got.out_bytes_valid),
                                    64'(want.out_bytes_valid));
                if (got.out_last !== want.out_last)
                    report_mismatch("out_last", 64'(got.out_last), 64'(want.out_last));
            end
        end
    end

    task automatic write_key(input logic idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == aes_pkg::REG_KEY_HIGH) key_reg[127:64] = val;
        else key_reg[63:0] = val;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_all();
        while (pending_words.size() > 0 || expected_cipher.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic load_words(input int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 19);
            if (r == 0) pending_words.push_back(random_word($urandom_range(17, 31)));
            else if (r == 1) pending_words.push_back(random_word(0));
            else if (r < 8) pending_words.push_back(random_word($urandom_range(1, 15)));
            else pending_words.push_back(random_word(16));
            if (r == 2) pending_words[$].block_number = 5'($urandom_range(0, 31));
        end
    endtask

    // stimulus
    initial begin
        t_ctr_word w;
        logic [63:0] key_set [4][2];
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = aes_pkg::REG_KEY_HIGH;
        i_cfg_data = '0;
        key_reg = '0;
        sender_hold = 1'b0;
        long_stall_req = 1'b0;
        error_count = 0;
        words_checked = 0;
        for (int i = 0; i < 256; i++) sub_table[i] = aes_pkg::sbox(i[7:0]);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset key, field extremes and odd counts
        w = random_word(16);
        w.nonce_high = '0; w.nonce_low = '0; w.data_high = '0; w.data_low = '0;
        w.block_number = 5'd1; w.last_block = 1'b0;
        pending_words.push_back(w);
        w.nonce_high = '1; w.nonce_low = '1; w.data_high = '1; w.data_low = '1;
        w.block_number = 5'd16; w.last_block = 1'b1;
        pending_words.push_back(w);
        for (int b = 0; b < 32; b += 3) begin
            w = random_word(b);
            w.block_number = b[4:0];
            pending_words.push_back(w);
        end
        w = random_word(31); w.block_number = 5'd31; pending_words.push_back(w);
        w = random_word(0); w.block_number = 5'd0; pending_words.push_back(w);
        drain_all();

        // random phases across key settings, extremes included
        key_set[0] = '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff};
        key_set[1] = '{64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c};
        key_set[2] = '{{$urandom, $urandom}, {$urandom, $urandom}};
        key_set[3] = '{64'h0, 64'h0};
        for (int ph = 0; ph < 4; ph++) begin
            write_key(aes_pkg::REG_KEY_HIGH, key_set[ph][0]);
            write_key(aes_pkg::REG_KEY_LOW, key_set[ph][1]);
            load_words(150);
            // long receiver hold-off while words keep coming
            repeat (20) @(posedge i_clk);
            long_stall_req = 1'b1;
            wait (stall_hold != 0);
            long_stall_req = 1'b0;
            load_words(150);
            drain_all();
        end
        // sender pause mid-stream until all results are back, then resume
        load_words(20);
        repeat (8) @(posedge i_clk);
        sender_hold = 1'b1;
        wait (expected_cipher.size() == 0 && !s_axis_tvalid);
        repeat (3) @(posedge i_clk);
        sender_hold = 1'b0;
        drain_all();

        $display("checked %0d cipher words under 5 key settings with stalls and bursts",
                 words_checked);
        if (error_count == 0) begin
            $display("PASS aes128_ctr_block_cipher");
        end else begin
            $display("FAIL aes128_ctr_block_cipher");
        end
        $finish;
    end

    // timeout
    initial begin
        #5_000_000;
        $display("FAIL aes128_ctr_block_cipher");
        $finish;
    end
endmodule
